/* hw/rtl/mbt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mbt_pkg: shared types and constants of the momentum trainer
// Word formats, parameter store port, saturation helper and the sigmoid
// table generator used at elaboration.
// ---------------------------------------------------------------------------
package mbt_pkg;

    localparam int HIDDEN_UNITS_DEF    = 3;
    localparam int SIGMOID_ENTRIES_DEF = 256;
    localparam int AW                  = 6;

    localparam logic [10:0] ETA_RESET   = 11'd870;
    localparam logic [10:0] ALPHA_RESET = 11'd246;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TRAIN = 2'd1,
        KIND_INFER = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        logic [10:0]        target;
        logic [5:0]         weight_index;
        logic signed [15:0] weight_value;
    } t_in_word;

    typedef struct packed {
        logic [10:0] y;
        logic        saturated;
    } t_out_word;

    typedef struct packed {
        logic               we;
        logic [AW-1:0]      waddr;
        logic signed [15:0] wdata;
        logic signed [15:0] sdata;
        logic [AW-1:0]      raddr;
    } t_mem_req;

    typedef struct packed {
        logic signed [15:0] val;
        logic               clip;
    } t_sat;

    function automatic t_sat sat16(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd32767) begin
            r.val  = 16'sh7FFF;
            r.clip = 1'b1;
        end else if (v < -64'sd32768) begin
            r.val  = 16'sh8000;
            r.clip = 1'b1;
        end else begin
            r.val  = v[15:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Shift-subtract quotient, elaboration use only.
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Logistic value for a non-negative Q5.10 point, Q1.10 result.
    function automatic longint unsigned sig_pos(input longint unsigned c);
        longint unsigned v;
        longint unsigned den;
        v = (64'd1 << 30) - (c * 64'd1024);
        for (int k = 0; k < 10; k++) begin
            v = (v * v) >> 30;
        end
        den = (64'd1 << 30) + v;
        return udiv((64'd1 << 40) + (den >> 1), den);
    endfunction

    function automatic logic [10:0] sig_entry(input int idx, input int entries);
        longint unsigned num;
        longint          centre;
        longint unsigned s;
        num    = 64'(2 * idx + 1) * 64'd8192;
        centre = longint'(udiv(num, 64'(entries))) - 64'sd8192;
        if (centre < 0) begin
            s = 64'd1024 - sig_pos(64'(-centre));
        end else begin
            s = sig_pos(64'(centre));
        end
        return s[10:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/mlp_backprop_momentum_trainer.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mlp_backprop_momentum_trainer: 2-H-1 sigmoid network trainer with momentum
// Load, infer and train words on a valid/stall channel, one result word each.
// ---------------------------------------------------------------------------
// Each input word is one of: load (write one weight or bias and clear its
// step), infer (forward pass), or train (forward pass then one update with
// momentum). Weights and steps live in a pair of single-port-write memories
// with registered reads; a sequencer walks the datapath over them one forward
// term or one update at a time. Each forward term takes a memory read and then
// a multiply-accumulate; each update takes a read, two multiply stages and a
// write. A stalled output holds the finished word in S_DONE until the output
// register is free. One word is in work at a time; a finished result sits in
// the output register while the next word is taken.
// Configuration (eta at byte 0, alpha at byte 4) is written over the APB port;
// the user must write it only while the block is idle, which the block itself
// does not enforce. Unwritten memory entries read as zero after reset.
// ---------------------------------------------------------------------------
module mlp_backprop_momentum_trainer import mbt_pkg::*; #(
    parameter int HIDDEN_UNITS    = HIDDEN_UNITS_DEF,
    parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int H   = HIDDEN_UNITS;
    localparam int CW  = $clog2(2 * H);
    localparam int TW  = (H + 1 > 3) ? $clog2(H + 1) : 2;
    localparam int HIW = (H > 1) ? $clog2(H) : 1;

    localparam logic [AW-1:0] A_HB = AW'(2 * H);
    localparam logic [AW-1:0] A_OW = AW'(3 * H);
    localparam logic [AW-1:0] A_OB = AW'(4 * H);

    typedef enum logic [3:0] {
        S_IDLE, S_F_RD, S_F_MAC, S_F_NET, S_F_ACT,
        S_D3_A, S_D3_B, S_D3_C,
        S_P_RD, S_S1, S_S2, S_S3,
        S_D2_A, S_D2_B, S_D2_C, S_DONE
    } t_state;

    typedef enum logic [1:0] {PH_OW, PH_OB, PH_HW, PH_HB} t_phase;

    t_state             r_state;
    t_phase             r_phase;
    t_in_word           r_in;
    logic [10:0]        r_eta;
    logic [10:0]        r_alpha;
    logic               r_hid;
    logic [CW-1:0]      r_cnt;
    logic [TW-1:0]      r_term;
    logic signed [39:0] r_acc;
    logic signed [15:0] r_net;
    logic [10:0]        r_h [H];
    logic signed [15:0] r_d2 [H];
    logic [10:0]        r_y;
    logic               r_sat;
    logic signed [15:0] r_d3;
    logic signed [31:0] r_p1;
    logic signed [31:0] r_p2;
    logic signed [51:0] r_p3;
    logic signed [15:0] r_wold;
    logic signed [15:0] r_wnew;
    logic               r_ovalid;
    t_out_word          r_oword;

    t_mem_req           mem_req;
    logic signed [15:0] mem_w;
    logic signed [15:0] mem_s;
    logic [10:0]        act;
    logic               in_accept;
    logic               cfg_wr;
    logic [AW-1:0]      term_addr;
    logic [AW-1:0]      phase_addr;
    logic signed [16:0] term_mul;
    logic signed [15:0] delta;
    logic signed [16:0] amul;
    logic               last_term;
    logic signed [32:0] n_prod;
    logic signed [39:0] n_netsum;
    t_sat               n_netsat;
    logic signed [12:0] n_err;
    logic [19:0]        n_yy;
    logic [19:0]        n_hh;
    logic signed [51:0] n_sum;
    t_sat               n_step;
    t_sat               n_wnew;
    t_sat               n_d3;
    t_sat               n_d2;
    logic signed [16:0] n_wsum;

    mbt_pstore #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_pstore (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mem_req),
        .o_weight (mem_w),
        .o_step   (mem_s)
    );

    mbt_sigmoid #(.SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_sigmoid (
        .i_net (r_net),
        .o_act (act)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign prdata      = paddr[2] ? {21'd0, r_alpha} : {21'd0, r_eta};

    // Address and operand selection for the forward terms and update phases.
    always_comb begin
        if (r_hid) begin
            unique case (r_term)
                TW'(0):  term_addr = A_HB + AW'(r_cnt);
                TW'(1):  term_addr = AW'(r_cnt) << 1;
                default: term_addr = (AW'(r_cnt) << 1) + AW'(1);
            endcase
            unique case (r_term)
                TW'(0):  term_mul = 17'sd1024;
                TW'(1):  term_mul = 17'(r_in.x0);
                default: term_mul = 17'(r_in.x1);
            endcase
            last_term = (r_term == TW'(2));
        end else begin
            if (r_term == TW'(0)) begin
                term_addr = A_OB;
                term_mul  = 17'sd1024;
            end else begin
                term_addr = A_OW + AW'(r_term - TW'(1));
                term_mul  = $signed({6'd0, r_h[HIW'(r_term - TW'(1))]});
            end
            last_term = (r_term == TW'(H));
        end

        unique case (r_phase)
            PH_OW: begin
                phase_addr = A_OW + AW'(r_cnt);
                delta      = r_d3;
                amul       = $signed({6'd0, r_h[HIW'(r_cnt)]});
            end
            PH_OB: begin
                phase_addr = A_OB;
                delta      = r_d3;
                amul       = 17'sd1024;
            end
            PH_HW: begin
                phase_addr = AW'(r_cnt);
                delta      = r_d2[HIW'(r_cnt >> 1)];
                amul       = r_cnt[0] ? 17'(r_in.x1) : 17'(r_in.x0);
            end
            default: begin
                phase_addr = A_HB + AW'(r_cnt);
                delta      = r_d2[HIW'(r_cnt)];
                amul       = 17'sd1024;
            end
        endcase
    end

    // Datapath arithmetic for the current state.
    always_comb begin
        n_prod   = 33'(mem_w) * 33'(term_mul);
        n_netsum = r_acc + 40'sd512;
        n_netsat = sat16(64'(n_netsum >>> 10));
        n_err    = $signed({2'd0, r_in.target}) - $signed({2'd0, r_y});
        n_yy     = 20'(r_y) * (20'd1024 - 20'(r_y));
        n_hh     = 20'(r_h[HIW'(r_cnt)]) * (20'd1024 - 20'(r_h[HIW'(r_cnt)]));
        n_d3     = sat16(64'((r_p3 + 52'sd524288) >>> 20));
        n_d2     = sat16(64'((r_p3 + 52'sd536870912) >>> 30));
        n_sum    = r_p3 + (52'(r_p2) <<< 10) + 52'sd524288;
        n_step   = sat16(64'(n_sum >>> 20));
        n_wsum   = 17'(r_wold) + 17'(n_step.val);
        n_wnew   = sat16(64'(n_wsum));
    end

    // Memory port: load writes at the word boundary, updates write back in S_S3.
    always_comb begin
        mem_req       = '0;
        mem_req.raddr = (r_state == S_F_RD) ? term_addr : phase_addr;
        if (r_state == S_IDLE) begin
            mem_req.we    = in_accept && (i_in_word.kind == KIND_LOAD)
                            && (i_in_word.weight_index <= A_OB);
            mem_req.waddr = i_in_word.weight_index;
            mem_req.wdata = i_in_word.weight_value;
            mem_req.sdata = '0;
        end else if (r_state == S_S3) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = phase_addr;
            mem_req.wdata = n_wnew.val;
            mem_req.sdata = n_step.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_OW;
            r_eta    <= ETA_RESET;
            r_alpha  <= ALPHA_RESET;
            r_ovalid <= 1'b0;
            r_hid    <= 1'b0;
            r_cnt    <= '0;
            r_term   <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_alpha <= pwdata[10:0];
                end else begin
                    r_eta <= pwdata[10:0];
                end
            end
            // drop the result once the far side takes it, unless a new one lands
            if (r_ovalid && !i_out_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_in   <= i_in_word;
                        r_sat  <= 1'b0;
                        r_y    <= '0;
                        r_hid  <= 1'b1;
                        r_cnt  <= '0;
                        r_term <= '0;
                        if (i_in_word.kind == KIND_TRAIN || i_in_word.kind == KIND_INFER) begin
                            r_state <= S_F_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_F_RD: begin
                    r_state <= S_F_MAC;
                end
                S_F_MAC: begin
                    if (r_term == TW'(0)) begin
                        r_acc <= 40'(n_prod);
                    end else begin
                        r_acc <= r_acc + 40'(n_prod);
                    end
                    if (last_term) begin
                        r_state <= S_F_NET;
                    end else begin
                        r_term  <= r_term + TW'(1);
                        r_state <= S_F_RD;
                    end
                end
                S_F_NET: begin
                    r_net   <= n_netsat.val;
                    r_sat   <= r_sat | n_netsat.clip;
                    r_state <= S_F_ACT;
                end
                S_F_ACT: begin
                    r_term <= '0;
                    if (r_hid) begin
                        r_h[HIW'(r_cnt)] <= act;
                        if (r_cnt == CW'(H - 1)) begin
                            r_hid <= 1'b0;
                            r_cnt <= '0;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_state <= S_F_RD;
                    end else begin
                        r_y <= act;
                        if (r_in.kind == KIND_TRAIN) begin
                            r_state <= S_D3_A;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_D3_A: begin
                    r_p1    <= 32'(n_err);
                    r_p2    <= $signed(32'(n_yy));
                    r_state <= S_D3_B;
                end
                S_D3_B: begin
                    r_p3    <= 52'(r_p1) * 52'(r_p2);
                    r_state <= S_D3_C;
                end
                S_D3_C: begin
                    r_d3    <= n_d3.val;
                    r_sat   <= r_sat | n_d3.clip;
                    r_phase <= PH_OW;
                    r_cnt   <= '0;
                    r_state <= S_P_RD;
                end
                S_P_RD: begin
                    r_state <= S_S1;
                end
                S_S1: begin
                    r_wold  <= mem_w;
                    r_p1    <= 32'($signed({1'b0, r_eta}) * 28'(delta));
                    r_p2    <= 32'($signed({1'b0, r_alpha}) * 28'(mem_s));
                    r_state <= S_S2;
                end
                S_S2: begin
                    r_p3    <= 52'(r_p1) * 52'(amul);
                    r_state <= S_S3;
                end
                S_S3: begin
                    r_wnew <= n_wnew.val;
                    r_sat  <= r_sat | n_step.clip | n_wnew.clip;
                    unique case (r_phase)
                        PH_OW: begin
                            r_state <= S_D2_A;
                        end
                        PH_OB: begin
                            r_phase <= PH_HW;
                            r_cnt   <= '0;
                            r_state <= S_P_RD;
                        end
                        PH_HW: begin
                            if (r_cnt == CW'(2 * H - 1)) begin
                                r_phase <= PH_HB;
                                r_cnt   <= '0;
                            end else begin
                                r_cnt <= r_cnt + CW'(1);
                            end
                            r_state <= S_P_RD;
                        end
                        default: begin
                            if (r_cnt == CW'(H - 1)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_cnt   <= r_cnt + CW'(1);
                                r_state <= S_P_RD;
                            end
                        end
                    endcase
                end
                S_D2_A: begin
                    // hidden error uses the freshly updated output weight
                    r_p1    <= $signed(32'(n_hh));
                    r_p2    <= 32'(r_d3) * 32'(r_wnew);
                    r_state <= S_D2_B;
                end
                S_D2_B: begin
                    r_p3    <= 52'(r_p1) * 52'(r_p2);
                    r_state <= S_D2_C;
                end
                S_D2_C: begin
                    r_d2[HIW'(r_cnt)] <= n_d2.val;
                    r_sat             <= r_sat | n_d2.clip;
                    if (r_cnt == CW'(H - 1)) begin
                        r_phase <= PH_OB;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_state <= S_P_RD;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid        <= 1'b1;
                        r_oword.y         <= r_y;
                        r_oword.saturated <= r_sat;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A taken word keeps the input side stalled on the next cycle.
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // Memory writes happen only for loads or in the write-back step.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == S_IDLE || r_state == S_S3))
        else $error("memory write outside load or write-back");

    // Sigmoid results never exceed one.
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.y <= 11'd1024))
        else $error("output above one");

endmodule
`default_nettype wire

/* hw/rtl/mbt_sigmoid.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mbt_sigmoid: sigmoid lookup
// Clamp the net to [-8, 8), bin it and read the constant table.
// ---------------------------------------------------------------------------
module mbt_sigmoid import mbt_pkg::*; #(
    parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
    input  logic signed [15:0] i_net,
    output logic [10:0]        o_act
);

    localparam int IW = $clog2(SIGMOID_ENTRIES);
    localparam int PW = 14 + IW + 1;

    logic [10:0]   rom [SIGMOID_ENTRIES];
    logic [13:0]   offs;
    logic [PW-1:0] prod;
    logic [IW-1:0] idx;

    for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
        assign rom[g] = sig_entry(g, SIGMOID_ENTRIES);
    end

    always_comb begin
        priority if (i_net < -16'sd8192) begin
            offs = '0;
        end else if (i_net > 16'sd8191) begin
            offs = 14'h3FFF;
        end else begin
            offs = 14'(i_net + 16'sd8192);
        end
        prod  = PW'(offs) * PW'(SIGMOID_ENTRIES);
        idx   = prod[14+IW-1:14];
        o_act = rom[idx];
    end

endmodule
`default_nettype wire

/* hw/rtl/mbt_pstore.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// mbt_pstore: weight and step memories
// One write and one registered read per cycle; unwritten entries read zero.
// ---------------------------------------------------------------------------
module mbt_pstore import mbt_pkg::*; #(
    parameter int HIDDEN_UNITS = HIDDEN_UNITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mem_req           i_req,
    output logic signed [15:0] o_weight,
    output logic signed [15:0] o_step
);

    localparam int DEPTH = 4 * HIDDEN_UNITS + 1;
    localparam int DW    = $clog2(DEPTH);

    logic signed [15:0] r_wmem [DEPTH];
    logic signed [15:0] r_smem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic signed [15:0] r_wq;
    logic signed [15:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr[DW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_wmem[i_req.waddr[DW-1:0]] <= i_req.wdata;
            r_smem[i_req.waddr[DW-1:0]] <= i_req.sdata;
        end
        if (r_valid[i_req.raddr[DW-1:0]]) begin
            r_wq <= r_wmem[i_req.raddr[DW-1:0]];
            r_sq <= r_smem[i_req.raddr[DW-1:0]];
        end else begin
            r_wq <= '0;
            r_sq <= '0;
        end
    end

    assign o_weight = r_wq;
    assign o_step   = r_sq;

endmodule
`default_nettype wire
